// ===== rtl/gpnm_pkg.sv =====
`default_nettype none

package gpnm_pkg;

  localparam int PHASE_W  = 16;
  localparam int NOISE_W  = 16;
  localparam int OFFSET_W = 16;
  localparam int MIX_W    = 17;
  localparam int SAMPLE_W = 18;
  localparam int CFG_W    = 17;
  localparam int INDEX_W  = 2;

  // Numerator and denominator of the pulse ratio; the cube of a 16 bit end needs 48 bits.
  localparam int NUM_W = 48;
  localparam int REM_W = NUM_W + 1;

  localparam logic [MIX_W-1:0] MIX_ONE = 17'h10000;

  localparam int SAMPLE_MAX = 131071;
  localparam int SAMPLE_MIN = -131072;

  localparam logic [INDEX_W-1:0] CFG_OPEN_END  = 2'd0;
  localparam logic [INDEX_W-1:0] CFG_CLOSE_END = 2'd1;
  localparam logic [INDEX_W-1:0] CFG_OFFSET    = 2'd2;
  localparam logic [INDEX_W-1:0] CFG_NOISE_MIX = 2'd3;

  typedef enum logic [1:0] {
    SEG_OPEN  = 2'd0,
    SEG_CLOSE = 2'd1,
    SEG_FLAT  = 2'd2
  } seg_t;

  // What travels down the pipeline beside the arithmetic.
  typedef struct packed {
    logic               valid;
    seg_t               seg;
    logic [NOISE_W-1:0] noise;
  } tag_t;

endpackage

`default_nettype wire

// ===== rtl/gpnm_front.sv =====
`default_nettype none

module gpnm_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [gpnm_pkg::PHASE_W-1:0]  phase,
  input  wire logic [gpnm_pkg::NOISE_W-1:0]  noise,
  input  wire logic [gpnm_pkg::PHASE_W-1:0]  open_end,
  input  wire logic [gpnm_pkg::PHASE_W-1:0]  close_end,
  output gpnm_pkg::tag_t                     tag,
  output logic      [gpnm_pkg::NUM_W-1:0]    num,
  output logic      [gpnm_pkg::NUM_W-1:0]    den
);

  import gpnm_pkg::*;

  localparam int SQ_W  = 2 * PHASE_W;
  localparam int LIN_W = PHASE_W + 2;

  // Stage one: segment decision and operand selection.
  tag_t               tag1;
  logic [PHASE_W-1:0] opa1;
  logic [PHASE_W-1:0] opb1;
  logic [PHASE_W-1:0] t1_1;
  logic [LIN_W-1:0]   lin1;

  seg_t               seg_c;
  logic [PHASE_W-1:0] opa_c;
  logic [PHASE_W-1:0] opb_c;
  logic [LIN_W-1:0]   lin_c;

  // Stage two: squares.
  tag_t               tag2;
  logic [SQ_W-1:0]    sqa2;
  logic [SQ_W-1:0]    sqb2;
  logic [PHASE_W-1:0] t1_2;
  logic [LIN_W-1:0]   lin2;

  // Stage three: numerator and denominator.
  logic [SQ_W+LIN_W-1:0]   num_prod;
  logic [SQ_W+PHASE_W-1:0] den_prod;
  logic [NUM_W-1:0]        num_c;
  logic [NUM_W-1:0]        den_c;

  always_comb begin
    opa_c = '0;
    opb_c = '0;
    if (phase < open_end) begin
      seg_c = SEG_OPEN;
      opa_c = phase;
      opb_c = open_end;
    end else if (phase < close_end) begin
      seg_c = SEG_CLOSE;
      opa_c = close_end - open_end;
      opb_c = phase - open_end;
    end else begin
      seg_c = SEG_FLAT;
    end
    // 3t - 2p is positive whenever the rising segment is taken.
    lin_c = LIN_W'({open_end, 1'b0}) + LIN_W'(open_end) - LIN_W'({phase, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
    end else if (en) begin
      tag1.valid <= in_valid;
      tag1.seg   <= seg_c;
      tag1.noise <= noise;
      opa1       <= opa_c;
      opb1       <= opb_c;
      t1_1       <= open_end;
      lin1       <= lin_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2.valid <= 1'b0;
    end else if (en) begin
      tag2 <= tag1;
      sqa2 <= opa1 * opa1;
      sqb2 <= opb1 * opb1;
      t1_2 <= t1_1;
      lin2 <= lin1;
    end
  end

  always_comb begin
    num_prod = sqa2 * lin2;
    den_prod = sqb2 * t1_2;
    unique case (tag2.seg)
      SEG_OPEN: begin
        num_c = num_prod[NUM_W-1:0];
        den_c = den_prod[NUM_W-1:0];
      end
      SEG_CLOSE: begin
        num_c = NUM_W'(sqa2 - sqb2);
        den_c = NUM_W'(sqa2);
      end
      default: begin
        // A zero over one gives a zero pulse without a special path.
        num_c = '0;
        den_c = NUM_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else if (en) begin
      tag <= tag2;
      num <= num_c;
      den <= den_c;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gpnm_div.sv =====
`default_nettype none

module gpnm_div #(
  parameter int FRAC = 14
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire gpnm_pkg::tag_t              tag_in,
  input  wire logic [gpnm_pkg::NUM_W-1:0]  num,
  input  wire logic [gpnm_pkg::NUM_W-1:0]  den,
  output gpnm_pkg::tag_t                   tag_out,
  output logic      [FRAC+1:0]             quo
);

  import gpnm_pkg::*;

  localparam int NS = FRAC + 2;
  localparam int QW = FRAC + 2;

  tag_t             tag_s [NS];
  logic [QW-1:0]    quo_s [NS];
  logic [REM_W-1:0] rem_s [NS-1];
  logic [NUM_W-1:0] den_s [NS-1];

  logic             ge0;
  logic [REM_W-1:0] rem0;

  // First stage takes the integer bit; the numerator never exceeds the denominator.
  always_comb begin
    ge0  = (num >= den);
    rem0 = ge0 ? ({1'b0, num} - {1'b0, den}) : {1'b0, num};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_s[0].valid <= 1'b0;
    end else if (en) begin
      tag_s[0] <= tag_in;
      quo_s[0] <= QW'(ge0);
      rem_s[0] <= rem0;
      den_s[0] <= den;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    logic [REM_W-1:0] shifted;
    logic             ge;
    logic [REM_W-1:0] rem_c;

    always_comb begin
      shifted = {rem_s[k-1][REM_W-2:0], 1'b0};
      ge      = (shifted >= {1'b0, den_s[k-1]});
      rem_c   = ge ? (shifted - {1'b0, den_s[k-1]}) : shifted;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_s[k].valid <= 1'b0;
      end else if (en) begin
        tag_s[k] <= tag_s[k-1];
        quo_s[k] <= {quo_s[k-1][QW-2:0], ge};
      end
    end

    if (k < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[k] <= rem_c;
          den_s[k] <= den_s[k-1];
        end
      end
    end
  end

  assign tag_out = tag_s[NS-1];
  assign quo     = quo_s[NS-1];

endmodule

`default_nettype wire

// ===== rtl/gpnm_mix.sv =====
`default_nettype none

module gpnm_mix #(
  parameter int FRAC = 14
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire gpnm_pkg::tag_t                        tag_in,
  input  wire logic        [FRAC+1:0]                quo,
  input  wire logic signed [gpnm_pkg::OFFSET_W-1:0]  offset_level,
  input  wire logic        [gpnm_pkg::MIX_W-1:0]     noise_mix,
  output gpnm_pkg::tag_t                             tag_out,
  output logic signed      [gpnm_pkg::SAMPLE_W-1:0]  sample
);

  import gpnm_pkg::*;

  localparam int VW    = (FRAC + 2 > OFFSET_W + 1) ? FRAC + 2 : OFFSET_W + 1;
  localparam int AW    = VW + MIX_W + 1;
  localparam int BW    = NOISE_W + MIX_W;
  localparam int SUM_W = VW + 35;
  localparam int RW    = SUM_W - 32;

  localparam logic signed [SUM_W-1:0]    HALF    = {{(SUM_W-32){1'b0}}, 1'b1, 31'd0};
  localparam logic signed [RW-1:0]       SAT_HI  = RW'(SAMPLE_MAX);
  localparam logic signed [RW-1:0]       SAT_LO  = RW'(SAMPLE_MIN);
  localparam logic signed [SAMPLE_W-1:0] OUT_MAX = SAMPLE_W'(SAMPLE_MAX);
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN = SAMPLE_W'(SAMPLE_MIN);

  logic [FRAC+2:0]      quo_inc;
  logic [FRAC:0]        pulse;
  logic signed [VW-1:0] v_c;
  logic [MIX_W-1:0]     wmix_c;

  tag_t                 tag1;
  logic signed [VW-1:0] v1;
  logic [MIX_W-1:0]     wmix1;
  logic [MIX_W-1:0]     onem1;

  tag_t                 tag2;
  logic signed [AW-1:0] a2;
  logic [BW-1:0]        b2;
  logic signed [AW-1:0] a_c;

  logic signed [SUM_W-1:0] sum_c;
  logic signed [RW-1:0]    res_c;
  logic signed [SAMPLE_W-1:0] sat_c;

  // Round the quotient half up, then add the offset.
  always_comb begin
    quo_inc = {1'b0, quo} + (FRAC+3)'(1);
    pulse   = quo_inc[FRAC+1:1];
    v_c     = VW'($signed({1'b0, pulse})) + VW'(offset_level);
    wmix_c  = (noise_mix > MIX_ONE) ? MIX_ONE : noise_mix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
    end else if (en) begin
      tag1  <= tag_in;
      v1    <= v_c;
      wmix1 <= wmix_c;
      onem1 <= MIX_ONE - wmix_c;
    end
  end

  assign a_c = v1 * $signed({1'b0, onem1});

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2.valid <= 1'b0;
    end else if (en) begin
      tag2 <= tag1;
      a2   <= a_c;
      b2   <= tag1.noise * wmix1;
    end
  end

  // Both terms are brought to a 2^-32 scale of the output step, so one floor shift rounds.
  always_comb begin
    sum_c = (SUM_W'(a2) <<< 16) + (SUM_W'($signed({1'b0, b2})) <<< FRAC) + HALF;
    res_c = $signed(sum_c[SUM_W-1:32]);
    if (res_c > SAT_HI) begin
      sat_c = OUT_MAX;
    end else if (res_c < SAT_LO) begin
      sat_c = OUT_MIN;
    end else begin
      sat_c = res_c[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else if (en) begin
      tag_out <= tag2;
      sample  <= sat_c;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/glottal_pulse_with_noise_mix_unit.sv =====
// Glottal source generator: a Rosenberg style pulse with an offset, blended with noise.
// Input stream s_*: one beat per sample, carrying a phase and a uniform noise value.
// Output stream m_*: one beat per input beat, in order, carrying the saturated
// sample in tdata and the pulse segment (opening, closing, closed) in tuser.
// Configuration channel cfg_*: writes the opening end, closing end, offset level
// and noise weight by index; it is always ready and should only be used while
// no samples are in flight.
// Throughput is one beat per clock while the skid register is empty. An accepted input
// beat reaches the output through the three operand stages, the OUT_FRAC_BITS + 2
// stages of the one-bit-per-stage divider, the three mixing stages and the output
// register.
// Reset empties the pipeline and clears all four registers to zero.
// When the receiver stalls, one finished beat parks in a skid register behind the
// output register; s_tready then drops until the output drains, and the whole
// pipeline holds without losing or repeating a beat.
`default_nettype none

module glottal_pulse_with_noise_mix_unit #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,    // phase [15:0], noise_sample [31:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,    // sample [17:0], zero [23:18]
  output logic      [1:0]  m_tuser,    // segment [1:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  import gpnm_pkg::*;

  logic [PHASE_W-1:0]         open_end;
  logic [PHASE_W-1:0]         close_end;
  logic signed [OFFSET_W-1:0] offset_level;
  logic [MIX_W-1:0]           noise_mix;

  logic en;
  logic in_valid;

  tag_t             tag_f;
  logic [NUM_W-1:0] num_f;
  logic [NUM_W-1:0] den_f;
  tag_t             tag_d;
  logic [OUT_FRAC_BITS+1:0] quo_d;
  tag_t             tag_m;
  logic signed [SAMPLE_W-1:0] sample_m;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  seg_t                       out_seg;
  logic                       skid_valid;
  logic signed [SAMPLE_W-1:0] skid_sample;
  seg_t                       skid_seg;

  logic push;
  logic pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_end     <= '0;
      close_end    <= '0;
      offset_level <= '0;
      noise_mix    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OPEN_END:  open_end     <= cfg_data[PHASE_W-1:0];
        CFG_CLOSE_END: close_end    <= cfg_data[PHASE_W-1:0];
        CFG_OFFSET:    offset_level <= $signed(cfg_data[OFFSET_W-1:0]);
        CFG_NOISE_MIX: noise_mix    <= cfg_data[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as a whole whenever the skid register is free.
  assign en       = !skid_valid;
  assign s_tready = en;
  assign in_valid = s_tvalid && en;

  gpnm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .phase     (s_tdata[15:0]),
    .noise     (s_tdata[31:16]),
    .open_end  (open_end),
    .close_end (close_end),
    .tag       (tag_f),
    .num       (num_f),
    .den       (den_f)
  );

  gpnm_div #(
    .FRAC (OUT_FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_in  (tag_f),
    .num     (num_f),
    .den     (den_f),
    .tag_out (tag_d),
    .quo     (quo_d)
  );

  gpnm_mix #(
    .FRAC (OUT_FRAC_BITS)
  ) u_mix (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .tag_in       (tag_d),
    .quo          (quo_d),
    .offset_level (offset_level),
    .noise_mix    (noise_mix),
    .tag_out      (tag_m),
    .sample       (sample_m)
  );

  assign push = en && tag_m.valid;
  assign pop  = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_sample <= skid_sample;
        out_seg    <= skid_seg;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid  <= 1'b1;
        out_sample <= sample_m;
        out_seg    <= tag_m.seg;
      end else begin
        skid_valid  <= 1'b1;
        skid_sample <= sample_m;
        skid_seg    <= tag_m.seg;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(24-SAMPLE_W){1'b0}}, out_sample};
  assign m_tuser  = out_seg;

endmodule

`default_nettype wire
